// File: rtl/drdc_pkg.sv
// shared types and constants of the hold-to-run relay drive controller
`default_nettype none

package drdc_pkg;

    // relay bank geometry
    localparam int RELAY_BITS  = 16;
    localparam int COMBO_COUNT = 4;
    localparam int BANK_W      = 16;
    localparam int COMBO_REGS  = 4;
    localparam int COMBO_W     = 15;
    localparam int COMBO_LIMIT = (COMBO_COUNT < COMBO_REGS) ? COMBO_COUNT : COMBO_REGS;

    // configuration port geometry
    localparam int CFG_W     = 16;
    localparam int CFG_IDX_W = 3;

    // active-low bank patterns
    localparam logic [BANK_W-1:0] ALL_OFF = (RELAY_BITS >= BANK_W) ? '1 :
        BANK_W'((64'd1 << RELAY_BITS) - 64'd1);
    localparam logic [BANK_W-1:0] MASTER_BIT = (RELAY_BITS <= BANK_W) ?
        BANK_W'(64'd1 << (RELAY_BITS - 1)) : '0;

    // saturation limit of the millisecond counters
    localparam logic [15:0] AGE_MAX = 16'hFFFF;

    // register reset values
    localparam logic [7:0]  DEBOUNCE_RST = 8'd25;
    localparam logic [15:0] CAP_RST      = 16'd30000;
    localparam logic [COMBO_W-1:0] COMBO0_RST = 15'd97;
    localparam logic [COMBO_W-1:0] COMBO1_RST = 15'd178;
    localparam logic [COMBO_W-1:0] COMBO2_RST = 15'd180;
    localparam logic [COMBO_W-1:0] COMBO3_RST = 15'd184;

    // command codes
    typedef enum logic [1:0] {
        CMD_TICK      = 2'd0,
        CMD_ARM_RELAY = 2'd1,
        CMD_ARM_COMBO = 2'd2,
        CMD_SAFE      = 2'd3
    } cmd_t;

    // event codes reported with each result
    typedef enum logic [3:0] {
        EV_NONE          = 4'd0,
        EV_REFUSED_UNARM = 4'd1,
        EV_REFUSED_LATCH = 4'd2,
        EV_RUN_START     = 4'd3,
        EV_RELEASE_STOP  = 4'd4,
        EV_CAP_STOP      = 4'd5,
        EV_FORCED_SAFE   = 4'd6,
        EV_ARMED         = 4'd7,
        EV_BAD_INDEX     = 4'd8
    } event_t;

    // configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_DEBOUNCE = 3'd0,
        REG_CAP      = 3'd1,
        REG_COMBO0   = 3'd2,
        REG_COMBO1   = 3'd3,
        REG_COMBO2   = 3'd4,
        REG_COMBO3   = 3'd5
    } reg_idx_t;

    // live configuration handed to the datapath
    typedef struct packed {
        logic [7:0]  debounce_ms;
        logic [15:0] cap_ms;
        logic [COMBO_REGS-1:0][COMBO_W-1:0] combo_mask;
    } cfg_t;

endpackage

`default_nettype wire

// File: rtl/drdc_ifs.sv
// valid/ready channel interfaces for command and result words
`default_nettype none

interface drdc_cmd_if;
    logic       valid;
    logic       ready;
    logic [1:0] command;
    logic       button_pressed;
    logic [3:0] select_index;

    modport source (output valid, output command, output button_pressed,
                    output select_index, input ready);
    modport sink   (input valid, input command, input button_pressed,
                    input select_index, output ready);
endinterface

interface drdc_res_if;
    logic        valid;
    logic        ready;
    logic [15:0] relay_bank;
    logic        drive_on;
    logic        is_armed;
    logic [3:0]  event_res;

    modport source (output valid, output relay_bank, output drive_on,
                    output is_armed, output event_res, input ready);
    modport sink   (input valid, input relay_bank, input drive_on,
                    input is_armed, input event_res, output ready);
endinterface

`default_nettype wire

// File: rtl/deadman_relay_drive_controller_unit.sv
// top level of the hold-to-run relay drive controller
`default_nettype none

// Hold-to-run relay drive controller. Each command word (tick, arm relay, arm combo,
// force safe) is handled in a single pass: the command and the current controller
// state feed one block of logic whose outcome is written into the state registers
// and into the result register at the accepting edge. A command is accepted every
// cycle that the result register is free, and its result word appears on the result
// channel in the next cycle; the single result register sets the one-word-per-cycle
// rate, and the command side keeps accepting whenever that register is empty or is
// being read in the same cycle. Configuration writes take effect at the next edge
// and should only be issued while no result is outstanding.
module deadman_relay_drive_controller_unit
    import drdc_pkg::*;
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    drdc_cmd_if.sink                  cmd,
    drdc_res_if.source                res,
    input  wire logic                 cfg_write_en,
    input  wire logic [CFG_IDX_W-1:0] cfg_index,
    input  wire logic [CFG_W-1:0]     cfg_wdata
);

    cfg_t cfg;

    // controller state
    logic              armed_reg,   armed_next;
    logic [BANK_W-1:0] mask_reg,    mask_next;
    logic              running_reg, running_next;
    logic              raw_reg,     raw_next;
    logic              stable_reg,  stable_next;
    logic [15:0]       age_reg,     age_next;
    logic [15:0]       elapsed_reg, elapsed_next;
    logic              latch_reg,   latch_next;

    // result register
    logic              res_valid_reg;
    logic [BANK_W-1:0] bank_reg,    bank_next;
    logic              drive_reg;
    logic              armed_out_reg;
    event_t            event_reg,   event_next;

    logic              accept;
    logic              over;
    logic              relay_ok;
    logic              combo_ok;

    drdc_cfg_regs u_cfg_regs (
        .clk      (clk),
        .rst_n    (rst_n),
        .write_en (cfg_write_en),
        .index    (cfg_index),
        .wdata    (cfg_wdata),
        .cfg      (cfg)
    );

    assign cmd.ready = !res_valid_reg || res.ready;
    assign accept    = cmd.valid && cmd.ready;

    assign relay_ok = 32'(cmd.select_index) < 32'(RELAY_BITS);
    assign combo_ok = 32'(cmd.select_index) < 32'(COMBO_LIMIT);

    // command decode and next state
    always_comb
    begin
        armed_next   = armed_reg;
        mask_next    = mask_reg;
        running_next = running_reg;
        raw_next     = raw_reg;
        stable_next  = stable_reg;
        age_next     = age_reg;
        elapsed_next = elapsed_reg;
        latch_next   = latch_reg;
        event_next   = EV_NONE;
        over         = 1'b0;

        case (cmd.command)
            CMD_TICK:
            begin
                // raw level and its age
                if (cmd.button_pressed != raw_reg)
                begin
                    raw_next = cmd.button_pressed;
                    age_next = '0;
                end
                else if (age_reg != AGE_MAX)
                begin
                    age_next = age_reg + 16'd1;
                end

                // run timer, cap checked against the pre-tick count
                if (running_reg)
                begin
                    over = elapsed_reg >= cfg.cap_ms;
                    if (elapsed_reg != AGE_MAX)
                        elapsed_next = elapsed_reg + 16'd1;
                end

                // debounced edge
                if (raw_next != stable_reg && age_next > {8'd0, cfg.debounce_ms})
                begin
                    stable_next = raw_next;
                    if (raw_next)
                    begin
                        if (!armed_reg)
                            event_next = EV_REFUSED_UNARM;
                        else if (latch_reg)
                            event_next = EV_REFUSED_LATCH;
                        else if (!running_reg)
                        begin
                            running_next = 1'b1;
                            elapsed_next = '0;
                            over         = 1'b0;
                            event_next   = EV_RUN_START;
                        end
                    end
                    else
                    begin
                        if (running_reg)
                        begin
                            running_next = 1'b0;
                            event_next   = EV_RELEASE_STOP;
                        end
                        latch_next = 1'b0;
                    end
                end

                // run-time cap
                if (running_next && over)
                begin
                    running_next = 1'b0;
                    latch_next   = 1'b1;
                    event_next   = EV_CAP_STOP;
                end
            end
            CMD_ARM_RELAY:
            begin
                if (relay_ok)
                begin
                    running_next = 1'b0;
                    armed_next   = 1'b1;
                    mask_next    = BANK_W'(1) << cmd.select_index;
                    latch_next   = 1'b0;
                    event_next   = EV_ARMED;
                end
                else
                begin
                    event_next = EV_BAD_INDEX;
                end
            end
            CMD_ARM_COMBO:
            begin
                if (combo_ok)
                begin
                    running_next = 1'b0;
                    armed_next   = 1'b1;
                    mask_next    = BANK_W'(cfg.combo_mask[cmd.select_index[1:0]]);
                    latch_next   = 1'b0;
                    event_next   = EV_ARMED;
                end
                else
                begin
                    event_next = EV_BAD_INDEX;
                end
            end
            CMD_SAFE:
            begin
                running_next = 1'b0;
                latch_next   = 1'b0;
                event_next   = EV_FORCED_SAFE;
            end
            default:
            begin
                event_next = EV_NONE;
            end
        endcase

        // active-low bank drive
        bank_next = running_next ? (ALL_OFF & ~(mask_next | MASTER_BIT)) : ALL_OFF;
    end

    // state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            armed_reg   <= 1'b0;
            mask_reg    <= '0;
            running_reg <= 1'b0;
            raw_reg     <= 1'b0;
            stable_reg  <= 1'b0;
            age_reg     <= '0;
            elapsed_reg <= '0;
            latch_reg   <= 1'b0;
        end
        else if (accept)
        begin
            armed_reg   <= armed_next;
            mask_reg    <= mask_next;
            running_reg <= running_next;
            raw_reg     <= raw_next;
            stable_reg  <= stable_next;
            age_reg     <= age_next;
            elapsed_reg <= elapsed_next;
            latch_reg   <= latch_next;
        end
    end

    // result word valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            res_valid_reg <= 1'b0;
        else if (accept)
            res_valid_reg <= 1'b1;
        else if (res.ready)
            res_valid_reg <= 1'b0;
    end

    // result word payload
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            bank_reg      <= bank_next;
            drive_reg     <= running_next;
            armed_out_reg <= armed_next;
            event_reg     <= event_next;
        end
    end

    assign res.valid      = res_valid_reg;
    assign res.relay_bank = bank_reg;
    assign res.drive_on   = drive_reg;
    assign res.is_armed   = armed_out_reg;
    assign res.event_res  = event_reg;

`ifndef SYNTHESIS
    // a running drive never coexists with the cap latch
    assert property (@(posedge clk) disable iff (!rst_n) !(running_reg && latch_reg))
        else $error("drive running while cap latch set");

    // energized outputs only when armed
    assert property (@(posedge clk) disable iff (!rst_n)
        res.valid && res.drive_on |-> res.is_armed)
        else $error("drive on while unarmed");

    // bank is all off whenever the drive is off
    assert property (@(posedge clk) disable iff (!rst_n)
        res.valid && !res.drive_on |-> res.relay_bank == ALL_OFF)
        else $error("relay bank not all off with drive off");

    // a run start word always reports the drive on
    assert property (@(posedge clk) disable iff (!rst_n)
        res.valid && res.event_res == EV_RUN_START |-> res.drive_on)
        else $error("run start without drive");

    // force safe leaves the drive stopped
    assert property (@(posedge clk) disable iff (!rst_n)
        accept && cmd.command == CMD_SAFE |=> !running_reg && !latch_reg)
        else $error("force safe did not stop the drive");
`endif

endmodule

`default_nettype wire

// File: rtl/drdc_cfg_regs.sv
// configuration register file of the relay drive controller
`default_nettype none

module drdc_cfg_regs
    import drdc_pkg::*;
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 write_en,
    input  wire logic [CFG_IDX_W-1:0] index,
    input  wire logic [CFG_W-1:0]     wdata,
    output cfg_t                      cfg
);

    cfg_t cfg_reg;
    cfg_t cfg_next;

    // register decode, unknown indexes are dropped
    always_comb
    begin
        cfg_next = cfg_reg;
        if (write_en)
        begin
            unique case (index)
                REG_DEBOUNCE: cfg_next.debounce_ms   = wdata[7:0];
                REG_CAP:      cfg_next.cap_ms        = wdata[15:0];
                REG_COMBO0:   cfg_next.combo_mask[0] = wdata[COMBO_W-1:0];
                REG_COMBO1:   cfg_next.combo_mask[1] = wdata[COMBO_W-1:0];
                REG_COMBO2:   cfg_next.combo_mask[2] = wdata[COMBO_W-1:0];
                REG_COMBO3:   cfg_next.combo_mask[3] = wdata[COMBO_W-1:0];
                default:      cfg_next = cfg_reg;
            endcase
        end
    end

    // register storage
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.debounce_ms   <= DEBOUNCE_RST;
            cfg_reg.cap_ms        <= CAP_RST;
            cfg_reg.combo_mask[0] <= COMBO0_RST;
            cfg_reg.combo_mask[1] <= COMBO1_RST;
            cfg_reg.combo_mask[2] <= COMBO2_RST;
            cfg_reg.combo_mask[3] <= COMBO3_RST;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

`default_nettype wire
